>>> src/sequential_list_engine_unit_macros.svh
// Assertion macros shared by the checker of the list engine.
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define SLE_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define SLE_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/sle_pkg.sv
// Types, codes and defaults shared by the list engine modules.
package sle_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int REQ_W  = 3;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 6;

  // Request codes; the two codes above clear are accepted and ignored.
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_GET    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOCATE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } sle_req_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [LEN_W-1:0]         list_length;
  } sle_rsp_t;

  // Controller to datapath, one strobe per kind of work.
  typedef struct packed {
    logic load;      // capture the request
    logic check;     // validate, set up the scan
    logic rd;        // issue one store read
    logic eval;      // act on the read data
    logic finish;    // final write and length update
    logic publish;   // load the result register
  } sle_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic bad;       // request rejected
    logic more;      // another entry to visit
  } sle_stat_t;

endpackage

>>> src/sequential_list_engine_unit.sv
// Top level of the list engine: ordered list of signed words in a one-port store.
//
// The engine keeps an ordered list of up to CAPACITY signed words and a length
// count, and serves one request at a time: insert at a 1-based position,
// delete at a position (returning the removed word), get, locate the first
// match, remove every equal word, or clear. Each request gives exactly one
// response carrying status, the word read, the found position and the new
// list length. A rejected request (bad position, or insert into a full list)
// leaves the list untouched. Request codes six and seven are accepted and
// answered with status ok and the current length. The words sit in a single
// store with one write and one registered read port, so every entry that an
// operation moves or inspects is first read, then acted on once the data is
// back. The entries visited are count-pos+1 for insert, count-pos+1 for
// delete, one for get, up to the first match for locate, count for remove
// and none for clear; a rejected request visits none. The next request is
// taken in the cycle after the response is loaded, and that does not wait for
// the previous response to be collected: the response register holds it
// while the following request is already at work. Store contents are
// undefined after reset; only the length is cleared, and only entries below
// the length are ever read.
module sequential_list_engine_unit #(
  parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  sle_pkg::sle_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sle_pkg::sle_rsp_t rsp
);
  import sle_pkg::*;

  // Strobes from the controller and scan status back from the datapath.
  sle_cmd_t  cmd;
  sle_stat_t stat;

  // Sequence each request: accept, check, scan the store, publish.
  sle_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the store, the length and the response register.
  sle_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

>>> src/sle_controller.sv
// Controller state machine of the list engine: sequencing and handshakes.
module sle_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  sle_pkg::sle_stat_t stat,
  output sle_pkg::sle_cmd_t  cmd
);
  import sle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOOP,
    S_EVAL,
    S_PUB
  } state_t;

  state_t state;

  // Refuse requests while reset is held.
  assign req_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd         = '0;
    cmd.load    = req_ready && req_valid;
    cmd.check   = (state == S_CHECK);
    cmd.rd      = (state == S_LOOP) && stat.more;
    cmd.finish  = (state == S_LOOP) && !stat.more;
    cmd.eval    = (state == S_EVAL);
    cmd.publish = (state == S_PUB) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          state <= stat.bad ? S_PUB : S_LOOP;
        end
        S_LOOP: begin
          state <= stat.more ? S_EVAL : S_PUB;
        end
        S_EVAL: begin
          state <= S_LOOP;
        end
        S_PUB: begin
          if (!rsp_valid || rsp_ready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      priority if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/sle_datapath.sv
// Datapath of the list engine: entry store, scan index and result register.
module sle_datapath #(
  parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sle_pkg::sle_req_t  req,
  input  sle_pkg::sle_cmd_t  cmd,
  output sle_pkg::sle_stat_t stat,
  output sle_pkg::sle_rsp_t  rsp
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CMP_W-1:0] CAP_E = CMP_W'(CAPACITY);

  logic [VALUE_BITS-1:0] mem [CAPACITY];

  logic [REQ_W-1:0]         op;
  logic [POS_W-1:0]         pos;
  logic [VALUE_BITS-1:0]    val;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         idx;
  logic [CNT_W-1:0]         wp;
  logic                     hit;
  logic [ST_W-1:0]          status_r;
  logic signed [DATA_W-1:0] rd_val;
  logic [POS_W-1:0]         found;
  logic [VALUE_BITS-1:0]    rdata;

  logic [CMP_W-1:0]      pos_e, cnt_e, idx_e, pos_m1;
  logic [CNT_W-1:0]      idx_m1;
  logic [ST_W-1:0]       status_chk;
  logic                  match, first;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic                  wr_en;
  logic [VALUE_BITS-1:0] wr_data;
  logic [63:0]           in_wide;
  logic signed [63:0]    out_wide;

  assign pos_e  = CMP_W'(pos);
  assign cnt_e  = CMP_W'(count);
  assign idx_e  = CMP_W'(idx);
  assign pos_m1 = pos_e - CMP_W'(1);
  assign idx_m1 = idx - CNT_W'(1);
  assign match  = (rdata == val);
  assign first  = ((idx_e + CMP_W'(1)) == pos_e);

  // Sign-extend the request value, then cut to the stored width.
  assign in_wide  = 64'(signed'(req.item_value));
  assign out_wide = 64'(signed'(rdata));

  always_comb begin
    status_chk = ST_OK;
    unique case (op)
      REQ_INSERT: begin
        if (pos == '0 || pos_e > cnt_e + CMP_W'(1)) status_chk = ST_RANGE;
        else if (cnt_e >= CAP_E)                     status_chk = ST_FULL;
      end
      REQ_DELETE, REQ_GET: begin
        if (pos == '0 || pos_e > cnt_e) status_chk = ST_RANGE;
      end
      default: status_chk = ST_OK;
    endcase
  end

  always_comb begin
    stat.bad = (status_chk != ST_OK);
    unique case (op)
      REQ_INSERT: stat.more = (idx_e >= pos_e);
      REQ_DELETE: stat.more = (idx_e < cnt_e);
      REQ_GET:    stat.more = first;
      REQ_LOCATE: stat.more = (idx_e < cnt_e) && !hit;
      REQ_REMOVE: stat.more = (idx_e < cnt_e);
      default:    stat.more = 1'b0;
    endcase
  end

  // Insert walks downwards and reads the entry below the index.
  assign rd_addr = (op == REQ_INSERT) ? idx_m1[AW-1:0] : idx[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rdata;
    if (cmd.eval) begin
      unique case (op)
        REQ_INSERT: begin
          wr_en = 1'b1;
        end
        REQ_DELETE: begin
          wr_en   = !first;
          wr_addr = idx_m1[AW-1:0];
        end
        REQ_REMOVE: begin
          wr_en   = !match;
          wr_addr = wp[AW-1:0];
        end
        default: wr_en = 1'b0;
      endcase
    end else if (cmd.finish && op == REQ_INSERT) begin
      wr_en   = 1'b1;
      wr_addr = pos_m1[AW-1:0];
      wr_data = val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req.req_type;
      pos <= req.position;
      val <= in_wide[VALUE_BITS-1:0];
    end

    if (cmd.check) begin
      status_r <= status_chk;
      wp       <= '0;
      hit      <= 1'b0;
      rd_val   <= '0;
      found    <= '0;
      unique case (op)
        REQ_INSERT:          idx <= count;
        REQ_DELETE, REQ_GET: idx <= pos_m1[CNT_W-1:0];
        default:             idx <= '0;
      endcase
    end

    if (cmd.eval) begin
      unique case (op)
        REQ_INSERT: begin
          idx <= idx_m1;
        end
        REQ_DELETE, REQ_GET: begin
          if (first) rd_val <= out_wide[DATA_W-1:0];
          idx <= idx + CNT_W'(1);
        end
        REQ_LOCATE: begin
          if (match) begin
            hit   <= 1'b1;
            found <= idx_e[POS_W-1:0] + POS_W'(1);
          end
          idx <= idx + CNT_W'(1);
        end
        REQ_REMOVE: begin
          if (!match) wp <= wp + CNT_W'(1);
          idx <= idx + CNT_W'(1);
        end
        default: idx <= idx;
      endcase
    end

    if (cmd.publish) begin
      rsp.status         <= status_r;
      rsp.read_value     <= rd_val;
      rsp.found_position <= found;
      rsp.list_length    <= cnt_e[LEN_W-1:0];
    end

    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      unique case (op)
        REQ_INSERT: count <= count + CNT_W'(1);
        REQ_DELETE: count <= count - CNT_W'(1);
        REQ_REMOVE: count <= wp;
        REQ_CLEAR:  count <= '0;
        default:    count <= count;
      endcase
    end
  end

endmodule

>>> src/sle_checker.sv
// Port-level checker for the list engine, bound to the top level.
`include "sequential_list_engine_unit_macros.svh"

module sle_checker #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input sle_pkg::sle_rsp_t rsp
);
  import sle_pkg::*;

  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CAPACITY);

  // Hold a response that has not been taken.
  `SLE_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response dropped or changed while stalled")

  // A rejected request returns no data.
  `SLE_CHECK(a_err_clean, rsp_valid && rsp.status != ST_OK, rsp.read_value == '0 && rsp.found_position == '0, "rejected request carries data")

  // Full status only when the list is at capacity.
  `SLE_CHECK(a_full_len, rsp_valid && rsp.status == ST_FULL, rsp.list_length == LEN_FULL, "full status with a short list")

  // A locate hit never comes with a read value.
  `SLE_CHECK(a_locate_clean, rsp_valid && rsp.found_position != '0, rsp.status == ST_OK && rsp.read_value == '0, "locate hit mixed with other result")

endmodule

bind sequential_list_engine_unit sle_checker #(
  .CAPACITY (CAPACITY)
) u_sle_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

>>> sim/sequential_list_engine_unit_test.sv
// Self-checking testbench for the ordered-list engine: directed and random requests.
`timescale 1ns / 100ps

module sequential_list_engine_unit_test;
  import sle_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  // Codes above clear: the engine takes them and changes nothing.
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
  // Longest request, such as remove-all over a full list.
  localparam int LONGEST_OP = 2 * CAP + 3;
  // Cycles with no handshake on either channel before giving up.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_CAP = 40;

  // Mirror of the list plus the queue of responses still owed by the engine.
  class list_tracker;
    logic signed [DATA_W-1:0] words[CAP];
    int                       length;
    sle_rsp_t                 due_responses[$];
    int                       errors;

    function new();
      length = 0;
      errors = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    // Apply one request to the mirror and return the response it must give.
    function sle_rsp_t apply_list_op(sle_req_t r);
      sle_rsp_t res;
      int       pos;
      int       k;
      int       w;
      res = '0;
      pos = int'(r.position);
      case (r.req_type)
        REQ_INSERT: begin
          if (pos < 1 || pos > length + 1) begin
            res.status = ST_RANGE;
          end else if (length >= CAP) begin
            res.status = ST_FULL;
          end else begin
            for (k = length; k >= pos; k--) words[k] = words[k-1];
            words[pos-1] = r.item_value;
            length++;
          end
        end
        REQ_DELETE: begin
          if (pos < 1 || pos > length) begin
            res.status = ST_RANGE;
          end else begin
            res.read_value = words[pos-1];
            for (k = pos; k < length; k++) words[k-1] = words[k];
            length--;
          end
        end
        REQ_GET: begin
          if (pos < 1 || pos > length) res.status = ST_RANGE;
          else res.read_value = words[pos-1];
        end
        REQ_LOCATE: begin
          for (k = 0; k < length; k++) begin
            if (words[k] == r.item_value) begin
              res.found_position = POS_W'(k + 1);
              break;
            end
          end
        end
        REQ_REMOVE: begin
          w = 0;
          for (k = 0; k < length; k++) begin
            if (words[k] != r.item_value) begin
              words[w] = words[k];
              w++;
            end
          end
          length = w;
        end
        REQ_CLEAR: length = 0;
        default: ;
      endcase
      res.list_length = LEN_W'(length);
      return res;
    endfunction

    function void note_request(sle_req_t r);
      due_responses.push_back(apply_list_op(r));
    endfunction

    task check_response(sle_rsp_t got);
      sle_rsp_t want;
      if (due_responses.size() == 0) begin
        report("response with no request outstanding");
      end else begin
        want = due_responses.pop_front();
        if (got.status !== want.status)
          report($sformatf("status expected %0d got %0d", want.status, got.status));
        if (got.read_value !== want.read_value)
          report($sformatf("read_value expected %0d got %0d",
                           want.read_value, got.read_value));
        if (got.found_position !== want.found_position)
          report($sformatf("found_position expected %0d got %0d",
                           want.found_position, got.found_position));
        if (got.list_length !== want.list_length)
          report($sformatf("list_length expected %0d got %0d",
                           want.list_length, got.list_length));
      end
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  sle_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  sle_rsp_t rsp;

  list_tracker board;
  int          send_idle;   // percent of cycles the sender holds off
  int          recv_stall;  // percent of cycles the receiver refuses
  int          quiet_cycles;

  sequential_list_engine_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: decide readiness at the falling edge for the next rising edge.
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // Check every response taken at a rising edge against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_response(rsp);
  end

  // Watchdog: count cycles in which neither channel moves a request or response.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic sle_req_t make_req(logic [REQ_W-1:0] op, int pos,
                                        logic signed [DATA_W-1:0] val);
    sle_req_t r;
    r.req_type   = op;
    r.position   = POS_W'(pos);
    r.item_value = val;
    return r;
  endfunction

  // Favour values already in the list so that locate and remove-all find matches.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40 && board.length > 0)
      return board.words[$urandom_range(0, board.length - 1)];
    if (roll < 70) return DATA_W'(int'($urandom_range(0, 7)) - 4);
    if (roll < 85) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return '1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  // Build one request; grow_pct tilts the mix towards inserts to fill the store.
  function automatic sle_req_t random_request(int grow_pct);
    logic [REQ_W-1:0] op;
    int               roll;
    int               pos;
    int               len;
    len  = board.length;
    roll = $urandom_range(0, 99);
    if (roll < grow_pct) begin
      op = REQ_INSERT;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 30)      op = REQ_INSERT;
      else if (roll < 47) op = REQ_DELETE;
      else if (roll < 64) op = REQ_GET;
      else if (roll < 81) op = REQ_LOCATE;
      else if (roll < 92) op = REQ_REMOVE;
      else if (roll < 95) op = REQ_CLEAR;
      else if (roll < 98) op = REQ_SPARE_LO;
      else                op = REQ_SPARE_HI;
    end
    // Mostly legal positions; now and then any 6-bit value.
    if ($urandom_range(0, 99) < 20)  pos = $urandom_range(0, 63);
    else if (op == REQ_INSERT)       pos = $urandom_range(1, len + 1);
    else if (len > 0)                pos = $urandom_range(1, len);
    else                             pos = 1;
    return make_req(op, pos, pick_value());
  endfunction

  // Offer one request, called just after a falling edge; returns after the
  // next falling edge with valid still high so back-to-back requests never
  // see valid dropped and raised within one step.
  task send_request(sle_req_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    board.note_request(r);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted response has been collected.
  task wait_drained();
    req_valid <= 1'b0;
    while (board.due_responses.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task run_phase(int items);
    sle_req_t r;
    int       done;
    int       seq;
    done = 0;
    seq  = 0;
    while (done < items) begin
      // Alternate stretches that fill the store with stretches that churn it.
      r = random_request(((seq / 40) % 2 == 0) ? 75 : 5);
      send_request(r);
      done++;
      seq++;
      if ($urandom_range(0, 149) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    board        = new();
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    send_idle    = 0;
    recv_stall   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty list, bad positions, value extremes, every operation.
    send_request(make_req(REQ_GET,    1,  32'sd0));
    send_request(make_req(REQ_DELETE, 1,  32'sd0));
    send_request(make_req(REQ_LOCATE, 0,  32'sd0));
    send_request(make_req(REQ_REMOVE, 0,  32'sd0));
    send_request(make_req(REQ_CLEAR,  0,  32'sd0));
    send_request(make_req(REQ_INSERT, 0,  32'sd5));
    send_request(make_req(REQ_INSERT, 2,  32'sd5));
    send_request(make_req(REQ_INSERT, 1,  32'sh8000_0000));
    send_request(make_req(REQ_INSERT, 2,  32'sh7fff_ffff));
    send_request(make_req(REQ_INSERT, 1,  -32'sd1));
    send_request(make_req(REQ_INSERT, 4,  32'sd0));
    send_request(make_req(REQ_INSERT, 63, 32'sd9));
    send_request(make_req(REQ_GET,    63, 32'sd0));
    send_request(make_req(REQ_GET,    4,  32'sd0));
    send_request(make_req(REQ_LOCATE, 0,  32'sh8000_0000));
    send_request(make_req(REQ_LOCATE, 0,  32'sd12345));
    send_request(make_req(REQ_DELETE, 1,  32'sd0));
    send_request(make_req(REQ_DELETE, 3,  32'sd0));
    send_request(make_req(REQ_INSERT, 2,  32'sh7fff_ffff));
    send_request(make_req(REQ_REMOVE, 0,  32'sh7fff_ffff));
    send_request(make_req(REQ_SPARE_LO, 42, -32'sd1));
    send_request(make_req(REQ_SPARE_HI, 21, 32'sd1));
    send_request(make_req(REQ_CLEAR,  63, -32'sd1));
    wait_drained();

    // Random phases under different back-pressure.
    run_phase(290);
    send_idle  = 87;
    run_phase(285);
    send_idle  = 0;
    recv_stall = 87;
    run_phase(285);
    send_idle  = 37;
    recv_stall = 37;
    run_phase(290);

    repeat (LONGEST_OP + 20) @(posedge clk);
    if (board.errors == 0 && board.due_responses.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
